FILE: hdl/bsw_pkg.sv
package bsw_pkg;

  // Default fixed-point format of a position: integer and fraction bits
  localparam int INT_BITS_DEF  = 8;
  localparam int FRAC_BITS_DEF = 16;

  // Fixed port widths
  localparam int POS_W    = 24;
  localparam int NODE_W   = 9;
  localparam int WEIGHT_W = 16;
  localparam int GRAD_W   = 18;
  localparam int REL_W    = 18;

  // Node offset within the kernel along one axis runs 0..2
  localparam int          OFF_W    = 2;
  localparam logic [1:0]  LAST_OFF = 2'd2;

  typedef struct packed {
    logic clamped;
    logic last_node;
  } beat_ctl_t;

endpackage

FILE: hdl/bsw_axis.sv
module bsw_axis #(
  parameter int INT_BITS  = bsw_pkg::INT_BITS_DEF,
  parameter int FRAC_BITS = bsw_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                load,
  input  logic [bsw_pkg::POS_W-1:0]           pos,
  input  logic [bsw_pkg::OFF_W-1:0]           sel,
  output logic [FRAC_BITS:0]                  weight,
  output logic [FRAC_BITS+1:0]                slope,
  output logic [bsw_pkg::NODE_W-1:0]          node,
  output logic [bsw_pkg::REL_W-1:0]           rel,
  output logic                                clamped
);

  localparam int PW = INT_BITS + FRAC_BITS;
  localparam int EW = (PW > bsw_pkg::POS_W) ? PW : bsw_pkg::POS_W;
  localparam int WW = FRAC_BITS + 1;
  localparam int SW = FRAC_BITS + 2;
  localparam int QW = 2 * FRAC_BITS + 3;
  localparam int NW = (INT_BITS + 1 > bsw_pkg::NODE_W) ? INT_BITS + 1 : bsw_pkg::NODE_W;
  localparam int RW = (FRAC_BITS + 3 > bsw_pkg::REL_W) ? FRAC_BITS + 3 : bsw_pkg::REL_W;

  localparam logic [PW-1:0] HALF_P       = PW'(2 ** (FRAC_BITS - 1));
  localparam logic [WW-1:0] ONE_W        = WW'(2 ** FRAC_BITS);
  localparam logic [WW-1:0] HALF_W       = WW'(2 ** (FRAC_BITS - 1));
  localparam logic [WW-1:0] THREE_HALF_W = WW'(3 * 2 ** (FRAC_BITS - 1));
  localparam logic [WW-1:0] THREE_QTR_W  = WW'(3 * 2 ** (FRAC_BITS - 2));
  localparam logic [QW-1:0] ONE_Q        = QW'(2 ** FRAC_BITS);
  localparam logic [QW-1:0] HALF_Q       = QW'(2 ** (FRAC_BITS - 1));

  logic [EW-1:0]       pos_ext;
  logic [PW-1:0]       p_raw;
  logic [PW-1:0]       p_clip;
  logic [PW-1:0]       p_shift;
  logic                clamp_c;
  logic [INT_BITS-1:0] base_c;
  logic [WW-1:0]       f_c;
  logic [WW-1:0]       d0, d1, d2;
  logic [QW-1:0]       sq0, sq1, sq2;
  logic [WW-1:0]       w_c [3];
  logic [SW-1:0]       s_c [3];
  logic [SW-1:0]       one_minus_f;

  logic [WW-1:0]       w_r [3];
  logic [SW-1:0]       s_r [3];
  logic [WW-1:0]       f_r;
  logic [INT_BITS-1:0] base_r;
  logic                clamp_r;

  logic [NW-1:0]       node_sum;
  logic [RW-1:0]       rel_sum;

  always_comb begin
    pos_ext = EW'(pos);
    p_raw   = pos_ext[PW-1:0];
    clamp_c = p_raw < HALF_P;
    p_clip  = clamp_c ? HALF_P : p_raw;
    p_shift = p_clip - HALF_P;
    base_c  = p_shift[PW-1:FRAC_BITS];
    f_c     = WW'(p_shift[FRAC_BITS-1:0]) + HALF_W;

    // Outer weights: 0.5*d^2 rounded half up; middle weight: 0.75 - d^2, d^2 rounded half up
    d0 = THREE_HALF_W - f_c;
    d2 = f_c - HALF_W;
    d1 = (f_c >= ONE_W) ? f_c - ONE_W : ONE_W - f_c;
    sq0 = QW'(d0) * QW'(d0) + ONE_Q;
    sq2 = QW'(d2) * QW'(d2) + ONE_Q;
    sq1 = QW'(d1) * QW'(d1) + HALF_Q;
    w_c[0] = sq0[FRAC_BITS+1 +: WW];
    w_c[1] = THREE_QTR_W - sq1[FRAC_BITS +: WW];
    w_c[2] = sq2[FRAC_BITS+1 +: WW];

    one_minus_f = SW'(ONE_W) - SW'(f_c);
    s_c[0] = SW'(f_c) - SW'(THREE_HALF_W);
    s_c[1] = {one_minus_f[SW-2:0], 1'b0};
    s_c[2] = SW'(f_c) - SW'(HALF_W);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      w_r     <= w_c;
      s_r     <= s_c;
      f_r     <= f_c;
      base_r  <= base_c;
      clamp_r <= clamp_c;
    end
  end

  always_comb begin
    case (sel)
      2'd0: begin
        weight = w_r[0];
        slope  = s_r[0];
      end
      2'd1: begin
        weight = w_r[1];
        slope  = s_r[1];
      end
      default: begin
        weight = w_r[2];
        slope  = s_r[2];
      end
    endcase
    node_sum = NW'(base_r) + NW'(sel);
    rel_sum  = (RW'(sel) << FRAC_BITS) - RW'(f_r);
    node     = node_sum[bsw_pkg::NODE_W-1:0];
    rel      = rel_sum[bsw_pkg::REL_W-1:0];
    clamped  = clamp_r;
  end

endmodule

FILE: hdl/bsw_merge.sv
module bsw_merge #(
  parameter int FRAC_BITS = bsw_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [FRAC_BITS:0]                  wx,
  input  logic [FRAC_BITS:0]                  wy,
  input  logic [FRAC_BITS:0]                  wz,
  input  logic [FRAC_BITS+1:0]                sx,
  input  logic [FRAC_BITS+1:0]                sy,
  input  logic [FRAC_BITS+1:0]                sz,
  input  logic [bsw_pkg::NODE_W-1:0]          nx,
  input  logic [bsw_pkg::NODE_W-1:0]          ny,
  input  logic [bsw_pkg::NODE_W-1:0]          nz,
  input  logic [bsw_pkg::REL_W-1:0]           rx,
  input  logic [bsw_pkg::REL_W-1:0]           ry,
  input  logic [bsw_pkg::REL_W-1:0]           rz,
  input  bsw_pkg::beat_ctl_t                  ctl_in,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [bsw_pkg::NODE_W-1:0]          node_x,
  output logic [bsw_pkg::NODE_W-1:0]          node_y,
  output logic [bsw_pkg::NODE_W-1:0]          node_z,
  output logic [bsw_pkg::WEIGHT_W-1:0]        node_weight,
  output logic signed [bsw_pkg::GRAD_W-1:0]   grad_x,
  output logic signed [bsw_pkg::GRAD_W-1:0]   grad_y,
  output logic signed [bsw_pkg::GRAD_W-1:0]   grad_z,
  output logic signed [bsw_pkg::REL_W-1:0]    rel_x,
  output logic signed [bsw_pkg::REL_W-1:0]    rel_y,
  output logic signed [bsw_pkg::REL_W-1:0]    rel_z,
  output bsw_pkg::beat_ctl_t                  ctl_out
);

  localparam int WW = FRAC_BITS + 1;
  localparam int SW = FRAC_BITS + 2;
  localparam int M1 = 2 * WW + 1;
  localparam int QW = M1 - FRAC_BITS;
  localparam int LW = (QW + WW + 1 > FRAC_BITS + bsw_pkg::GRAD_W) ?
                      QW + WW + 1 : FRAC_BITS + bsw_pkg::GRAD_W;

  localparam logic [M1-1:0] HALF_M = M1'(2 ** (FRAC_BITS - 1));
  localparam logic [LW-1:0] HALF_L = LW'(2 ** (FRAC_BITS - 1));

  // Slope times weight, rounded on the magnitude, sign restored
  function automatic logic [bsw_pkg::GRAD_W-1:0] grad_of(input logic [SW-1:0] s,
                                                         input logic [QW-1:0] w);
    logic [SW-1:0]              mag;
    logic [LW-1:0]              prod;
    logic [bsw_pkg::GRAD_W-1:0] r;
    mag  = s[SW-1] ? -s : s;
    prod = LW'(mag) * LW'(w) + HALF_L;
    r    = prod[FRAC_BITS +: bsw_pkg::GRAD_W];
    return s[SW-1] ? -r : r;
  endfunction

  logic          s1_valid;
  logic          s1_en;
  logic          s2_en;
  logic [M1-1:0] pxy, pyz, pxz;
  logic [LW-1:0] pw;

  logic [QW-1:0]                 s1_wxy, s1_wyz, s1_wxz;
  logic [WW-1:0]                 s1_wz;
  logic [SW-1:0]                 s1_sx, s1_sy, s1_sz;
  logic [bsw_pkg::NODE_W-1:0]    s1_nx, s1_ny, s1_nz;
  logic [bsw_pkg::REL_W-1:0]     s1_rx, s1_ry, s1_rz;
  bsw_pkg::beat_ctl_t            s1_ctl;

  assign s2_en    = !out_valid || out_ready;
  assign s1_en    = !s1_valid || s2_en;
  assign in_ready = s1_en;

  always_comb begin
    pxy = M1'(wx) * M1'(wy) + HALF_M;
    pyz = M1'(wy) * M1'(wz) + HALF_M;
    pxz = M1'(wx) * M1'(wz) + HALF_M;
    pw  = LW'(s1_wxy) * LW'(s1_wz) + HALF_L;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_valid <= in_valid;
      end
      if (s2_en) begin
        out_valid <= s1_valid;
      end
    end
  end

  // Pair products of the axis weights
  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_wxy <= pxy[FRAC_BITS +: QW];
      s1_wyz <= pyz[FRAC_BITS +: QW];
      s1_wxz <= pxz[FRAC_BITS +: QW];
      s1_wz  <= wz;
      s1_sx  <= sx;
      s1_sy  <= sy;
      s1_sz  <= sz;
      s1_nx  <= nx;
      s1_ny  <= ny;
      s1_nz  <= nz;
      s1_rx  <= rx;
      s1_ry  <= ry;
      s1_rz  <= rz;
      s1_ctl <= ctl_in;
    end
  end

  // Output register: full weight and gradients
  always_ff @(posedge clk) begin
    if (s2_en) begin
      node_weight <= pw[FRAC_BITS +: bsw_pkg::WEIGHT_W];
      grad_x      <= grad_of(s1_sx, s1_wyz);
      grad_y      <= grad_of(s1_sy, s1_wxz);
      grad_z      <= grad_of(s1_sz, s1_wxy);
      node_x      <= s1_nx;
      node_y      <= s1_ny;
      node_z      <= s1_nz;
      rel_x       <= s1_rx;
      rel_y       <= s1_ry;
      rel_z       <= s1_rz;
      ctl_out     <= s1_ctl;
    end
  end

endmodule

FILE: hdl/quadratic_bspline_mpm_weights.sv
// Quadratic B-spline MPM weights, 3x3x3 kernel. Each accepted particle
// position (one beat) yields 27 node beats, x offset outermost and z offset
// innermost, with last_node set on the 27th. One node beat leaves per cycle
// while out_ready holds; the shared weight-product pipeline serves one node
// per cycle unless the node side stalls it. The next position is accepted
// in the cycle its predecessor's last node enters the pipeline, so particles
// stream without gaps. An accepted position passes the axis lane registers,
// the pair-product register and the output register before its first node beat.
// Positions below one half per axis are clamped to one half and flag all 27 beats.
module quadratic_bspline_mpm_weights #(
  parameter int INT_BITS  = bsw_pkg::INT_BITS_DEF,
  parameter int FRAC_BITS = bsw_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [bsw_pkg::POS_W-1:0]           pos_x,
  input  logic [bsw_pkg::POS_W-1:0]           pos_y,
  input  logic [bsw_pkg::POS_W-1:0]           pos_z,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [bsw_pkg::NODE_W-1:0]          node_x,
  output logic [bsw_pkg::NODE_W-1:0]          node_y,
  output logic [bsw_pkg::NODE_W-1:0]          node_z,
  output logic [bsw_pkg::WEIGHT_W-1:0]        node_weight,
  output logic signed [bsw_pkg::GRAD_W-1:0]   grad_x,
  output logic signed [bsw_pkg::GRAD_W-1:0]   grad_y,
  output logic signed [bsw_pkg::GRAD_W-1:0]   grad_z,
  output logic signed [bsw_pkg::REL_W-1:0]    rel_x,
  output logic signed [bsw_pkg::REL_W-1:0]    rel_y,
  output logic signed [bsw_pkg::REL_W-1:0]    rel_z,
  output logic                                clamped,
  output logic                                last_node
);

  logic                        busy;
  logic                        load;
  logic                        issue;
  logic                        last_idx;
  logic                        m_ready;
  logic [bsw_pkg::OFF_W-1:0]   ci, cj, ck;

  logic [FRAC_BITS:0]          wx, wy, wz;
  logic [FRAC_BITS+1:0]        sx, sy, sz;
  logic [bsw_pkg::NODE_W-1:0]  nx, ny, nz;
  logic [bsw_pkg::REL_W-1:0]   rx, ry, rz;
  logic                        cx, cy, cz;
  bsw_pkg::beat_ctl_t          ctl_in;
  bsw_pkg::beat_ctl_t          ctl_out;

  assign last_idx = (ci == bsw_pkg::LAST_OFF) && (cj == bsw_pkg::LAST_OFF) &&
                    (ck == bsw_pkg::LAST_OFF);
  assign issue    = busy && m_ready;
  assign in_ready = !busy || (issue && last_idx);
  assign load     = in_valid && in_ready;

  assign ctl_in.clamped   = cx | cy | cz;
  assign ctl_in.last_node = last_idx;
  assign clamped          = ctl_out.clamped;
  assign last_node        = ctl_out.last_node;

  // Walk the 27 kernel nodes; the counters wrap back to zero on the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      ci   <= '0;
      cj   <= '0;
      ck   <= '0;
    end else begin
      if (load) begin
        busy <= 1'b1;
      end else if (issue && last_idx) begin
        busy <= 1'b0;
      end
      if (issue) begin
        if (ck == bsw_pkg::LAST_OFF) begin
          ck <= '0;
          if (cj == bsw_pkg::LAST_OFF) begin
            cj <= '0;
            ci <= (ci == bsw_pkg::LAST_OFF) ? '0 : ci + 1'b1;
          end else begin
            cj <= cj + 1'b1;
          end
        end else begin
          ck <= ck + 1'b1;
        end
      end
    end
  end

  bsw_axis #(.INT_BITS(INT_BITS), .FRAC_BITS(FRAC_BITS)) u_axis_x (
    .clk(clk), .load(load), .pos(pos_x), .sel(ci),
    .weight(wx), .slope(sx), .node(nx), .rel(rx), .clamped(cx)
  );

  bsw_axis #(.INT_BITS(INT_BITS), .FRAC_BITS(FRAC_BITS)) u_axis_y (
    .clk(clk), .load(load), .pos(pos_y), .sel(cj),
    .weight(wy), .slope(sy), .node(ny), .rel(ry), .clamped(cy)
  );

  bsw_axis #(.INT_BITS(INT_BITS), .FRAC_BITS(FRAC_BITS)) u_axis_z (
    .clk(clk), .load(load), .pos(pos_z), .sel(ck),
    .weight(wz), .slope(sz), .node(nz), .rel(rz), .clamped(cz)
  );

  bsw_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
    .clk(clk), .rst(rst),
    .in_valid(busy), .in_ready(m_ready),
    .wx(wx), .wy(wy), .wz(wz),
    .sx(sx), .sy(sy), .sz(sz),
    .nx(nx), .ny(ny), .nz(nz),
    .rx(rx), .ry(ry), .rz(rz),
    .ctl_in(ctl_in),
    .out_valid(out_valid), .out_ready(out_ready),
    .node_x(node_x), .node_y(node_y), .node_z(node_z),
    .node_weight(node_weight),
    .grad_x(grad_x), .grad_y(grad_y), .grad_z(grad_z),
    .rel_x(rel_x), .rel_y(rel_y), .rel_z(rel_z),
    .ctl_out(ctl_out)
  );

endmodule

FILE: tb/sv/quadratic_bspline_mpm_weights_test.sv
module quadratic_bspline_mpm_weights_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     FRAC        = bsw_pkg::FRAC_BITS_DEF;
  localparam longint ONE_FX      = longint'(1) << bsw_pkg::FRAC_BITS_DEF;
  localparam longint HALF_FX     = longint'(1) << (bsw_pkg::FRAC_BITS_DEF - 1);
  localparam longint THREE_QTR   = 3 * (ONE_FX >>> 2);
  localparam longint POS_MASK    =
    (longint'(1) << (bsw_pkg::INT_BITS_DEF + bsw_pkg::FRAC_BITS_DEF)) - 1;
  localparam int     NODES       = 27;
  localparam int     RANDOM_ITEMS = 446;
  localparam int     HOLD_CYCLES = 300;
  localparam int     QUIET_LIMIT = 4000;
  localparam int     DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [bsw_pkg::NODE_W-1:0]          nx;
    logic [bsw_pkg::NODE_W-1:0]          ny;
    logic [bsw_pkg::NODE_W-1:0]          nz;
    logic [bsw_pkg::WEIGHT_W-1:0]        weight;
    logic signed [bsw_pkg::GRAD_W-1:0]   gx;
    logic signed [bsw_pkg::GRAD_W-1:0]   gy;
    logic signed [bsw_pkg::GRAD_W-1:0]   gz;
    logic signed [bsw_pkg::REL_W-1:0]    rx;
    logic signed [bsw_pkg::REL_W-1:0]    ry;
    logic signed [bsw_pkg::REL_W-1:0]    rz;
    logic                                clamp;
    logic                                last_flag;
  } node_beat_t;

  typedef struct packed {
    logic [bsw_pkg::POS_W-1:0] x;
    logic [bsw_pkg::POS_W-1:0] y;
    logic [bsw_pkg::POS_W-1:0] z;
    logic                      typed;
    node_beat_t                first_node;
  } particle_row_t;

  logic                              clk;
  logic                              rst;
  logic                              in_valid;
  logic                              in_ready;
  logic [bsw_pkg::POS_W-1:0]         pos_x;
  logic [bsw_pkg::POS_W-1:0]         pos_y;
  logic [bsw_pkg::POS_W-1:0]         pos_z;
  logic                              out_valid;
  logic                              out_ready;
  logic [bsw_pkg::NODE_W-1:0]        node_x;
  logic [bsw_pkg::NODE_W-1:0]        node_y;
  logic [bsw_pkg::NODE_W-1:0]        node_z;
  logic [bsw_pkg::WEIGHT_W-1:0]      node_weight;
  logic signed [bsw_pkg::GRAD_W-1:0] grad_x;
  logic signed [bsw_pkg::GRAD_W-1:0] grad_y;
  logic signed [bsw_pkg::GRAD_W-1:0] grad_z;
  logic signed [bsw_pkg::REL_W-1:0]  rel_x;
  logic signed [bsw_pkg::REL_W-1:0]  rel_y;
  logic signed [bsw_pkg::REL_W-1:0]  rel_z;
  logic                              clamped;
  logic                              last_node;

  node_beat_t    node_beats_due[$];
  int            mismatches;
  logic          gaps_on;
  logic          hold_off;
  logic          row_typed;
  node_beat_t    row_first;
  particle_row_t directed_rows [14];

  quadratic_bspline_mpm_weights u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .pos_z       (pos_z),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .node_x      (node_x),
    .node_y      (node_y),
    .node_z      (node_z),
    .node_weight (node_weight),
    .grad_x      (grad_x),
    .grad_y      (grad_y),
    .grad_z      (grad_z),
    .rel_x       (rel_x),
    .rel_y       (rel_y),
    .rel_z       (rel_z),
    .clamped     (clamped),
    .last_node   (last_node)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Non-negative product rounded half up to the fraction width
  function automatic longint mul_round(longint a, longint b);
    return (a * b + HALF_FX) >>> FRAC;
  endfunction

  // Round a signed product by its magnitude, then restore the sign
  function automatic longint smul_round(longint s, longint u);
    longint r;
    r = mul_round((s < 0) ? -s : s, u);
    return (s < 0) ? -r : r;
  endfunction

  function automatic void predict_kernel_nodes(input logic [bsw_pkg::POS_W-1:0] px, py, pz);
    longint     pos [3];
    longint     frac [3];
    longint     base [3];
    longint     wgt [9];
    longint     slope [9];
    longint     p;
    longint     d;
    longint     e;
    longint     sq;
    longint     wxy;
    logic       hit_clamp;
    node_beat_t b;
    int         n;
    pos[0] = longint'(px);
    pos[1] = longint'(py);
    pos[2] = longint'(pz);
    hit_clamp = 1'b0;
    for (int a = 0; a < 3; a++) begin
      p = pos[a] & POS_MASK;
      if (p < HALF_FX) begin
        p = HALF_FX;
        hit_clamp = 1'b1;
      end
      base[a] = (p - HALF_FX) >>> FRAC;
      frac[a] = p - (base[a] << FRAC);
      d = ONE_FX + HALF_FX - frac[a];
      wgt[a*3] = (d * d + ONE_FX) >>> (FRAC + 1);
      e = frac[a] - ONE_FX;
      d = (e < 0) ? -e : e;
      sq = (d * d + HALF_FX) >>> FRAC;
      wgt[a*3+1] = THREE_QTR - sq;
      d = frac[a] - HALF_FX;
      wgt[a*3+2] = (d * d + ONE_FX) >>> (FRAC + 1);
      slope[a*3]   = frac[a] - (ONE_FX + HALF_FX);
      slope[a*3+1] = -2 * e;
      slope[a*3+2] = frac[a] - HALF_FX;
    end
    n = 0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        for (int k = 0; k < 3; k++) begin
          wxy = mul_round(wgt[i], wgt[3+j]);
          b.nx = 9'(base[0] + i);
          b.ny = 9'(base[1] + j);
          b.nz = 9'(base[2] + k);
          b.weight = 16'(mul_round(wxy, wgt[6+k]));
          b.gx = 18'(smul_round(slope[i], mul_round(wgt[3+j], wgt[6+k])));
          b.gy = 18'(smul_round(slope[3+j], mul_round(wgt[i], wgt[6+k])));
          b.gz = 18'(smul_round(slope[6+k], wxy));
          b.rx = 18'((longint'(i) << FRAC) - frac[0]);
          b.ry = 18'((longint'(j) << FRAC) - frac[1]);
          b.rz = 18'((longint'(k) << FRAC) - frac[2]);
          b.clamp = hit_clamp;
          b.last_flag = (n == NODES - 1);
          n++;
          node_beats_due.push_back(b);
        end
      end
    end
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Predict on each accepted position, compare each accepted node beat
  always @(posedge clk) begin
    node_beat_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        predict_kernel_nodes(pos_x, pos_y, pos_z);
        if (row_typed)
          node_beats_due[node_beats_due.size() - NODES] = row_first;
      end
      if (out_valid && out_ready) begin
        if (node_beats_due.size() == 0) begin
          $error("node beat with nothing expected: node_x %0d node_y %0d node_z %0d",
                 node_x, node_y, node_z);
          mismatches++;
        end else begin
          want = node_beats_due.pop_front();
          check_field("node_x", want.nx, node_x);
          check_field("node_y", want.ny, node_y);
          check_field("node_z", want.nz, node_z);
          check_field("node_weight", want.weight, node_weight);
          check_field("grad_x", want.gx, grad_x);
          check_field("grad_y", want.gy, grad_y);
          check_field("grad_z", want.gz, grad_z);
          check_field("rel_x", want.rx, rel_x);
          check_field("rel_y", want.ry, rel_y);
          check_field("rel_z", want.rz, rel_z);
          check_field("clamped", want.clamp, clamped);
          check_field("last_node", want.last_flag, last_node);
        end
      end
    end
  end

  // Node side: random stalls, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off = 1'b0;
      end
      out_ready <= !(gaps_on && ($urandom_range(99) < 9));
    end
  end

  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("FAILED: results differ");
    $finish;
  end

  task automatic offer_position(input logic [bsw_pkg::POS_W-1:0] x, y, z,
                                input logic typed, input node_beat_t first_node);
    @(negedge clk);
    if (gaps_on && ($urandom_range(99) < 9)) begin
      in_valid <= 1'b0;
      do @(negedge clk); while (gaps_on && ($urandom_range(99) < 9));
    end
    in_valid  <= 1'b1;
    pos_x     <= x;
    pos_y     <= y;
    pos_z     <= z;
    row_typed = typed;
    row_first = first_node;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Mostly full range, some in the clamp region, some near a half-integer
  function automatic logic [bsw_pkg::POS_W-1:0] random_axis();
    int pick;
    pick = $urandom_range(99);
    if (pick < 15)
      return bsw_pkg::POS_W'($urandom_range(16'hFFFF));
    else if (pick < 30)
      return bsw_pkg::POS_W'((32'($urandom_range(255)) << 16) + 32'h7FFF +
                             $urandom_range(2));
    else
      return bsw_pkg::POS_W'($urandom);
  endfunction

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    pos_x     = '0;
    pos_y     = '0;
    pos_z     = '0;
    gaps_on   = 1'b1;
    hold_off  = 1'b0;
    row_typed = 1'b0;
    row_first = '0;
    mismatches = 0;
    directed_rows = '{
      // all axes clamped: weights one half, one half, zero
      '{24'h000000, 24'h000000, 24'h000000, 1'b1,
        '{9'd0, 9'd0, 9'd0, 16'd8192, -18'sd16384, -18'sd16384, -18'sd16384,
          -18'sd32768, -18'sd32768, -18'sd32768, 1'b1, 1'b0}},
      // offset exactly one: outer weights one eighth
      '{24'h010000, 24'h010000, 24'h010000, 1'b1,
        '{9'd0, 9'd0, 9'd0, 16'd128, -18'sd512, -18'sd512, -18'sd512,
          -18'sd65536, -18'sd65536, -18'sd65536, 1'b0, 1'b0}},
      '{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b0, node_beat_t'('0)},
      '{24'h007FFF, 24'h007FFF, 24'h007FFF, 1'b0, node_beat_t'('0)},
      '{24'h008000, 24'h008000, 24'h008000, 1'b0, node_beat_t'('0)},
      '{24'h017FFF, 24'h017FFF, 24'h017FFF, 1'b0, node_beat_t'('0)},
      '{24'h018000, 24'h018000, 24'h018000, 1'b0, node_beat_t'('0)},
      '{24'h000000, 24'hFFFFFF, 24'h008000, 1'b0, node_beat_t'('0)},
      '{24'hFFFFFF, 24'h000000, 24'h123456, 1'b0, node_beat_t'('0)},
      '{24'hAAAAAA, 24'h555555, 24'h0F0F0F, 1'b0, node_beat_t'('0)},
      '{24'h555555, 24'hAAAAAA, 24'hF0F0F0, 1'b0, node_beat_t'('0)},
      '{24'h00FFFF, 24'h020000, 24'h7FFFFF, 1'b0, node_beat_t'('0)},
      '{24'h800000, 24'h00C000, 24'h004000, 1'b0, node_beat_t'('0)},
      '{24'h00FFFF, 24'h00FFFF, 24'h00FFFF, 1'b0, node_beat_t'('0)}
    };
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r])
      offer_position(directed_rows[r].x, directed_rows[r].y, directed_rows[r].z,
                     directed_rows[r].typed, directed_rows[r].first_node);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // a long stretch with both sides streaming flat out
      gaps_on = !(n >= 150 && n < 300);
      // stall the node side while positions keep coming
      if (n == 320)
        hold_off = 1'b1;
      offer_position(random_axis(), random_axis(), random_axis(), 1'b0, node_beat_t'('0));
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (node_beats_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
